[rtl/erc_pkg.sv]
// Package for the elevator request controller: floor count, field widths,
// request codes, controller states and the payload and command structs.
// No dependencies.
package erc_pkg;

  localparam int NumFloors = 4;
  localparam int FloorW    = 3;
  localparam int FloorIdxW = (NumFloors > 1) ? $clog2(NumFloors) : 1;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_DOWN = 2'd1,
    KIND_UP   = 2'd2,
    KIND_STOP = 2'd3
  } kind_e;

  typedef enum logic {
    MODE_REQUEST = 1'b0,
    MODE_TICK    = 1'b1
  } mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_HOLD = 1'b1
  } state_e;

  typedef struct packed {
    logic              mode;
    logic [FloorW-1:0] req_floor;
    logic [1:0]        req_kind;
  } in_t;

  typedef struct packed {
    logic [FloorW-1:0] car_floor;
    logic              going_up;
    logic              stopped;
    logic [FloorW-1:0] stop_floor;
    logic              moved;
    logic              pending;
  } out_t;

  typedef struct packed {
    logic load;
  } cmd_t;

endpackage

[rtl/erc_in_if.sv]
// Input stream interface of the elevator request controller.
// Depends on erc_pkg for the payload type.
interface erc_in_if;
  logic         valid;
  logic         ready;
  erc_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/erc_out_if.sv]
// Result stream interface of the elevator request controller.
// Depends on erc_pkg for the payload type.
interface erc_out_if;
  logic          valid;
  logic          ready;
  erc_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/erc_ctrl.sv]
// Handshake controller: tracks whether a result is held and issues the load
// command to the datapath. Depends on erc_pkg.
module erc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output erc_pkg::cmd_t cmd_o
);

  erc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= erc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_o = 1'b0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      erc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = erc_pkg::ST_HOLD;
        end
      end
      erc_pkg::ST_HOLD: begin
        out_valid_o = 1'b1;
        // take the next transaction in the cycle the held result leaves
        in_ready_o  = out_ready_i;
        if (out_ready_i && !in_valid_i) begin
          state_d = erc_pkg::ST_IDLE;
        end
      end
      default: state_d = erc_pkg::ST_IDLE;
    endcase
    cmd_o.load = in_valid_i && in_ready_o;
  end

endmodule

[rtl/erc_datapath.sv]
// Datapath: per-floor request store, car position and direction, and the
// result register. Updated on the load command. Depends on erc_pkg.
module erc_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  erc_pkg::cmd_t cmd_i,
  input  erc_pkg::in_t  item_i,
  output erc_pkg::out_t result_o
);

  localparam int N  = erc_pkg::NumFloors;
  localparam int FW = erc_pkg::FloorW;
  localparam int IW = erc_pkg::FloorIdxW;
  localparam logic [FW-1:0] FloorOne  = FW'(1);
  localparam logic [FW-1:0] FloorLast = FW'(erc_pkg::NumFloors);

  erc_pkg::kind_e kind_q   [N];
  erc_pkg::kind_e kind_d   [N];
  logic [FW-1:0]  origin_q [N];
  logic [FW-1:0]  origin_d [N];
  logic [N-1:0]   passed_q, passed_d, passed_mark;
  logic [FW-1:0]  floor_q, floor_d;
  logic           up_q, up_d;
  logic [FW-1:0]  last_q, last_d;
  erc_pkg::out_t  result_q, result_d;

  logic           is_tick, req_ok, pend_now, pend_next, at_end, same_dir, serve, up_new;
  logic [IW-1:0]  req_idx, cur_idx;
  erc_pkg::kind_e in_kind, cur_kind;

  always_comb begin
    is_tick  = (item_i.mode == erc_pkg::MODE_TICK);
    in_kind  = erc_pkg::kind_e'(item_i.req_kind);
    req_ok   = (item_i.req_floor != '0) && (item_i.req_floor <= FloorLast);
    req_idx  = IW'(item_i.req_floor - FloorOne);
    cur_idx  = IW'(floor_q - FloorOne);

    pend_now = 1'b0;
    for (int i = 0; i < N; i++) begin
      pend_now       = pend_now | (kind_q[i] != erc_pkg::KIND_NONE);
      passed_mark[i] = (origin_q[i] == floor_q) && (kind_q[i] == erc_pkg::KIND_STOP);
    end

    cur_kind = kind_q[cur_idx];
    at_end   = (floor_q == FloorOne) || (floor_q == FloorLast);
    same_dir = (up_q && cur_kind == erc_pkg::KIND_UP) ||
               (!up_q && cur_kind == erc_pkg::KIND_DOWN);
    serve    = same_dir || (cur_kind != erc_pkg::KIND_NONE && at_end) ||
               (cur_kind == erc_pkg::KIND_STOP && (passed_q[cur_idx] | passed_mark[cur_idx]));
    priority if (floor_q == FloorOne) begin
      up_new = 1'b1;
    end else if (floor_q == FloorLast) begin
      up_new = 1'b0;
    end else begin
      up_new = up_q;
    end

    for (int i = 0; i < N; i++) begin
      kind_d[i]   = kind_q[i];
      origin_d[i] = origin_q[i];
    end
    passed_d = passed_q;
    floor_d  = floor_q;
    up_d     = up_q;
    last_d   = last_q;
    result_d = result_q;

    if (cmd_i.load) begin
      result_d.stopped    = 1'b0;
      result_d.stop_floor = '0;
      result_d.moved      = 1'b0;
      if (!is_tick) begin
        if (req_ok) begin
          if (kind_q[req_idx] != erc_pkg::KIND_STOP) begin
            kind_d[req_idx] = in_kind;
          end
          if (in_kind == erc_pkg::KIND_STOP) begin
            origin_d[req_idx] = last_q;
          end
          passed_d[req_idx] = 1'b0;
          last_d            = item_i.req_floor;
        end
      end else if (pend_now) begin
        passed_d = passed_q | passed_mark;
        if (serve) begin
          kind_d[cur_idx]     = erc_pkg::KIND_NONE;
          result_d.stopped    = 1'b1;
          result_d.stop_floor = floor_q;
        end
        up_d    = up_new;
        floor_d = up_new ? floor_q + FloorOne : floor_q - FloorOne;
        result_d.moved = 1'b1;
      end
      pend_next = 1'b0;
      for (int i = 0; i < N; i++) begin
        pend_next = pend_next | (kind_d[i] != erc_pkg::KIND_NONE);
      end
      result_d.car_floor = floor_d;
      result_d.going_up  = up_d;
      result_d.pending   = pend_next;
    end else begin
      pend_next = pend_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        kind_q[i]   <= erc_pkg::KIND_NONE;
        origin_q[i] <= '0;
      end
      passed_q <= '0;
      floor_q  <= FloorOne;
      up_q     <= 1'b1;
      last_q   <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        kind_q[i]   <= kind_d[i];
        origin_q[i] <= origin_d[i];
      end
      passed_q <= passed_d;
      floor_q  <= floor_d;
      up_q     <= up_d;
      last_q   <= last_d;
    end
  end

  // result payload needs no reset: it is shown only with valid
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o = result_q;

endmodule

[rtl/elevator_request_controller.sv]
// Top level of the sweeping elevator request controller.
// Depends on erc_pkg, erc_in_if, erc_out_if, erc_ctrl and erc_datapath.
//
//  port   | dir | payload                                       | handshake
//  in_i   | in  | mode, req_floor, req_kind                     | valid/ready
//  out_o  | out | car_floor, going_up, stopped, stop_floor,     | valid/ready
//         |     | moved, pending                                |
//
// Each transaction is evaluated in the cycle it is accepted; its result is
// valid from the next cycle and held in the output register until taken.
// A new transaction is accepted while the result register is empty or is
// being emptied in the same cycle, so one item per cycle without stalls.
// Reset (rst_ni low, asynchronous) clears all requests, puts the car at
// floor one heading up, and clears the last-request floor.
module elevator_request_controller (
  input  logic      clk_i,
  input  logic      rst_ni,
  erc_in_if.sink    in_i,
  erc_out_if.source out_o
);

  erc_pkg::cmd_t cmd;

  erc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  erc_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (in_i.data),
    .result_o (out_o.data)
  );

endmodule

[tb/sv/erc_sweep_check.sv]
// Checker for the elevator request controller: watches both streams, keeps
// its own copy of the sweep state and compares every result against it.
// Depends on erc_pkg, erc_in_if and erc_out_if.
module erc_sweep_check (
  input  logic clk_i,
  input  logic rst_ni,
  erc_in_if    in_mon,
  erc_out_if   out_mon,
  output int   fail_count_o,
  output int   backlog_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import erc_pkg::*;

  kind_e             floor_kind   [NumFloors];
  logic [FloorW-1:0] floor_origin [NumFloors];
  logic              origin_seen  [NumFloors];
  logic [FloorW-1:0] car_at;
  logic              car_up;
  logic [FloorW-1:0] last_floor;

  out_t car_status_q[$];
  out_t want;
  int   fail_count = 0;

  assign fail_count_o = fail_count;

  function automatic logic calls_waiting();
    logic any;
    any = 1'b0;
    for (int i = 0; i < NumFloors; i++) begin
      if (floor_kind[i] != KIND_NONE) any = 1'b1;
    end
    return any;
  endfunction

  function automatic out_t next_car_status(in_t item);
    out_t        r;
    int unsigned idx;
    kind_e       k;
    logic        at_end;
    logic        same_dir;
    r = '0;
    if (item.mode == MODE_REQUEST) begin
      // Floors outside 1..NumFloors leave every register untouched
      if (item.req_floor >= 1 && item.req_floor <= NumFloors) begin
        idx = item.req_floor - 1;
        if (floor_kind[idx] != KIND_STOP) floor_kind[idx] = kind_e'(item.req_kind);
        if (kind_e'(item.req_kind) == KIND_STOP) floor_origin[idx] = last_floor;
        origin_seen[idx] = 1'b0;
        last_floor = item.req_floor;
      end
    end else if (calls_waiting()) begin
      idx = car_at - 1;
      // Car stops requested from this floor now count as passed
      for (int i = 0; i < NumFloors; i++) begin
        if (floor_origin[i] == car_at && floor_kind[i] == KIND_STOP) origin_seen[i] = 1'b1;
      end
      k        = floor_kind[idx];
      at_end   = (car_at == 1) || (car_at == NumFloors);
      same_dir = (car_up && k == KIND_UP) || (!car_up && k == KIND_DOWN);
      if (same_dir || (k != KIND_NONE && at_end) || (k == KIND_STOP && origin_seen[idx])) begin
        floor_kind[idx] = KIND_NONE;
        r.stopped       = 1'b1;
        r.stop_floor    = car_at;
      end
      if (car_at == 1) begin
        car_up = 1'b1;
      end else if (car_at == NumFloors) begin
        car_up = 1'b0;
      end
      car_at  = car_up ? car_at + 1'b1 : car_at - 1'b1;
      r.moved = 1'b1;
    end
    r.car_floor = car_at;
    r.going_up  = car_up;
    r.pending   = calls_waiting();
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumFloors; i++) begin
        floor_kind[i]   = KIND_NONE;
        floor_origin[i] = '0;
        origin_seen[i]  = 1'b0;
      end
      car_at     = 1;
      car_up     = 1'b1;
      last_floor = '0;
      car_status_q.delete();
    end else begin
      // Retire the result first: a transaction accepted on this edge
      // cannot have produced it
      if (out_mon.valid && out_mon.ready) begin
        if (car_status_q.size() == 0) begin
          $error("result with no transaction waiting: %p", out_mon.data);
          fail_count++;
        end else begin
          want = car_status_q.pop_front();
          check_field("car_floor", want.car_floor, out_mon.data.car_floor);
          check_field("going_up", want.going_up, out_mon.data.going_up);
          check_field("stopped", want.stopped, out_mon.data.stopped);
          check_field("stop_floor", want.stop_floor, out_mon.data.stop_floor);
          check_field("moved", want.moved, out_mon.data.moved);
          check_field("pending", want.pending, out_mon.data.pending);
        end
      end
      if (in_mon.valid && in_mon.ready) car_status_q.push_back(next_car_status(in_mon.data));
    end
    backlog_o = car_status_q.size();
  end

endmodule

[tb/sv/elevator_request_controller_test.sv]
// Top of the elevator request controller testbench: clock, reset, request
// and tick stimulus, result-side stalls, and the verdict.
// Depends on erc_pkg, erc_in_if, erc_out_if, erc_sweep_check and the RTL.
module elevator_request_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import erc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int LongHold   = 300;
  localparam int DrainWait  = 5;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   backlog;
  int   cycles = 0;

  int source_idle_pct = 0;
  int sink_stall_pct  = 0;
  int holds_asked     = 0;

  erc_in_if  in_if ();
  erc_out_if out_if ();

  elevator_request_controller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  erc_sweep_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .backlog_o    (backlog)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles == CycleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_served != holds_asked) begin
        holds_served++;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Offer one transaction and return at the edge where it is taken
  task automatic send_item(in_t item);
    while ($urandom_range(99) < source_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_request(int req_floor, kind_e kind);
    in_t item;
    item.mode      = MODE_REQUEST;
    item.req_floor = FloorW'(req_floor);
    item.req_kind  = kind;
    send_item(item);
  endtask

  // Floor and kind are don't-care on a tick: randomize them anyway
  task automatic send_tick();
    in_t item;
    item.mode      = MODE_TICK;
    item.req_floor = FloorW'($urandom_range(7));
    item.req_kind  = 2'($urandom_range(3));
    send_item(item);
  endtask

  initial begin
    int pick;
    int odd_floor;
    rst_ni      = 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle tick, car stop with no origin, out-of-range floors,
    // protected car stop, hall call cleared by kind none, then a full sweep
    send_tick();
    send_request(3, KIND_STOP);
    send_request(0, KIND_UP);
    send_request(7, KIND_DOWN);
    send_request(5, KIND_STOP);
    send_request(2, KIND_UP);
    send_request(4, KIND_DOWN);
    send_request(1, KIND_STOP);
    send_request(3, KIND_UP);
    send_request(2, KIND_NONE);
    send_request(2, KIND_DOWN);
    repeat (9) send_tick();
    send_request(4, KIND_UP);
    send_request(6, KIND_NONE);
    repeat (3) send_tick();

    // Random: phases of idling and stalls, last one with a long hold-off
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin source_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin source_idle_pct = 86; sink_stall_pct = 0;  end
        2: begin source_idle_pct = 0;  sink_stall_pct = 86; end
        3: begin source_idle_pct = 36; sink_stall_pct = 36; end
        default: begin
          source_idle_pct = 0;
          sink_stall_pct  = 0;
          holds_asked++;
        end
      endcase
      repeat (90) begin
        pick = $urandom_range(99);
        if (pick < 48) begin
          send_tick();
        end else if (pick < 94) begin
          send_request($urandom_range(NumFloors, 1), kind_e'($urandom_range(3)));
        end else begin
          odd_floor = $urandom_range(3);
          send_request((odd_floor == 0) ? 0 : odd_floor + 4, kind_e'($urandom_range(3)));
        end
      end
    end
    in_if.valid <= 1'b0;

    while (backlog != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
